// ===== rtl/core/sckr_pkg.sv =====
package sckr_pkg;

    // Time of day as held by the clock
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } clk_time_t;

    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [5:0] SECONDS_PER_MIN  = 6'd60;

    // Selected field codes
    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;

    // Event kinds carried in tuser
    localparam logic ACT_SECOND = 1'b0;
    localparam logic ACT_FAST   = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCAN_DIVISOR    = 2'd0;
    localparam logic [1:0] CFG_HOLD_DELAY      = 2'd1;
    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;

    localparam logic [7:0]  SCAN_DIVISOR_RST    = 8'd6;
    localparam logic [15:0] HOLD_DELAY_RST      = 16'd200;
    localparam logic [7:0]  REPEAT_INTERVAL_RST = 8'd10;

    // Step the selected field by one, wrapping at its limit
    function automatic clk_time_t bump_field(input clk_time_t t, input logic [1:0] sel);
        clk_time_t  r;
        logic [4:0] h_inc;
        logic [5:0] m_inc;
        logic [5:0] s_inc;
        r     = t;
        h_inc = t.hours + 5'd1;
        m_inc = t.minutes + 6'd1;
        s_inc = t.seconds + 6'd1;
        case (sel)
            FIELD_HOURS:   r.hours   = (h_inc >= HOURS_PER_DAY)    ? 5'd0 : h_inc;
            FIELD_MINUTES: r.minutes = (m_inc >= MINUTES_PER_HOUR) ? 6'd0 : m_inc;
            FIELD_SECONDS: r.seconds = (s_inc >= SECONDS_PER_MIN)  ? 6'd0 : s_inc;
            default:       r = t;
        endcase
        return r;
    endfunction

    // Advance by one second with carries into minutes and hours
    function automatic clk_time_t tick_second(input clk_time_t t);
        clk_time_t  r;
        logic [4:0] h_inc;
        logic [5:0] m_inc;
        logic [5:0] s_inc;
        r     = t;
        h_inc = t.hours + 5'd1;
        m_inc = t.minutes + 6'd1;
        s_inc = t.seconds + 6'd1;
        if (s_inc >= SECONDS_PER_MIN) begin
            r.seconds = 6'd0;
            if (m_inc >= MINUTES_PER_HOUR) begin
                r.minutes = 6'd0;
                r.hours   = (h_inc >= HOURS_PER_DAY) ? 5'd0 : h_inc;
            end else begin
                r.minutes = m_inc;
            end
        end else begin
            r.seconds = s_inc;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/settable_clock_with_key_repeat.sv =====
// Settable 24-hour clock with three keys and auto-repeat on the increment key.
//
// Input channel (s_): one beat per event. s_tuser gives the kind: a one-second
// tick (0) or a fast tick (1) whose s_tdata carries the three key levels.
// Result channel (m_): exactly one beat per input beat, carrying the time,
// the selected field and the edit flag after that event.
//
// Each event is folded into the clock state by a single combinational step
// at the accepting edge; the result is held in an output register and shown
// in the cycle after acceptance. One beat per cycle is sustained: the input is
// taken whenever the output register is empty or is being emptied that cycle.
// When the receiver stalls, the output beat holds and s_tready drops until
// it is taken, so no event is lost.
//
// Reset (aresetn low, synchronous) clears the time to 00:00:00 in edit mode
// with hours selected, drops all key latches and counters, empties the output
// register and loads the configuration defaults (scan 6, hold 200, repeat 10).
// Configuration writes land on the cfg_we edge and are meant for idle periods.
module settable_clock_with_key_repeat
    import sckr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key1_down, [1] key2_down, [2] key3_down, rest zero
    input  logic        s_tuser,   // [0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] hour_value, [10:5] minute_value,
                                   // [16:11] second_value, [18:17] selected_field,
                                   // [19] editing, rest zero

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration
    logic [7:0]  scan_div_reg;
    logic [15:0] hold_delay_reg;
    logic [7:0]  repeat_int_reg;

    // Clock state
    clk_time_t   time_reg,      time_next;
    logic [1:0]  field_sel_reg, field_sel_next;
    logic        edit_reg,      edit_next;
    logic [2:0]  latch_reg,     latch_next;    // bit0 key1, bit1 key2, bit2 key3
    logic        armed_reg,     armed_next;
    logic [15:0] hold_cnt_reg,  hold_cnt_next;
    logic [7:0]  rpt_cnt_reg,   rpt_cnt_next;
    logic [7:0]  scan_cnt_reg,  scan_cnt_next;

    // Output register
    logic        out_valid_reg;
    logic [19:0] out_data_reg, out_data_next;

    logic        accept;
    logic        key1, key2, key3;

    // Fast tick pre-scan values
    logic [7:0]  scan_inc;
    logic [15:0] hold_dec;
    logic [7:0]  rpt_inc;
    logic        do_scan;
    logic [1:0]  sel_after_k1;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign key1     = s_tdata[0];
    assign key2     = s_tdata[1];
    assign key3     = s_tdata[2];

    assign scan_inc = scan_cnt_reg + 8'd1;
    assign hold_dec = (hold_cnt_reg != 16'd0) ? hold_cnt_reg - 16'd1 : 16'd0;
    assign rpt_inc  = rpt_cnt_reg + 8'd1;
    // A zero divisor scans on every fast tick
    assign do_scan  = (scan_inc >= scan_div_reg);

    // Key1 steps the selection in edit mode only; its latch ignores it while running
    always_comb begin
        sel_after_k1 = field_sel_reg;
        if (key1 && !latch_reg[0] && edit_reg) begin
            sel_after_k1 = (field_sel_reg >= FIELD_SECONDS) ? FIELD_HOURS
                                                            : field_sel_reg + 2'd1;
        end
    end

    // Event step
    always_comb begin
        time_next      = time_reg;
        field_sel_next = field_sel_reg;
        edit_next      = edit_reg;
        latch_next     = latch_reg;
        armed_next     = armed_reg;
        hold_cnt_next  = hold_cnt_reg;
        rpt_cnt_next   = rpt_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;

        if (s_tuser == ACT_SECOND) begin
            // Hold the time while editing
            if (!edit_reg) begin
                time_next = tick_second(time_reg);
            end
        end else begin
            scan_cnt_next = scan_inc;
            hold_cnt_next = hold_dec;
            rpt_cnt_next  = rpt_inc;
            if (do_scan) begin
                scan_cnt_next = 8'd0;

                // Key1: field select
                if (key1 && !latch_reg[0] && edit_reg) begin
                    latch_next[0] = 1'b1;
                end else if (!key1 && latch_reg[0]) begin
                    latch_next[0] = 1'b0;
                end
                field_sel_next = sel_after_k1;

                // Key2: increment, then auto-repeat once the hold timer has run out
                if (key2 && !latch_reg[1]) begin
                    latch_next[1] = 1'b1;
                    hold_cnt_next = hold_delay_reg;
                    armed_next    = 1'b1;
                    if (edit_reg) begin
                        time_next = bump_field(time_reg, sel_after_k1);
                    end
                end else if (!key2 && latch_reg[1]) begin
                    latch_next[1] = 1'b0;
                    armed_next    = 1'b0;
                    hold_cnt_next = 16'd0;
                end else if (armed_reg && hold_dec == 16'd0 && edit_reg) begin
                    if (rpt_inc >= repeat_int_reg) begin
                        rpt_cnt_next = 8'd0;
                        time_next    = bump_field(time_reg, sel_after_k1);
                    end
                end

                // Key3: run/edit toggle; entering run selects hours
                if (key3 && !latch_reg[2]) begin
                    latch_next[2] = 1'b1;
                    if (edit_reg) begin
                        edit_next      = 1'b0;
                        field_sel_next = FIELD_HOURS;
                    end else begin
                        edit_next = 1'b1;
                    end
                end else if (!key3 && latch_reg[2]) begin
                    latch_next[2] = 1'b0;
                end
            end
        end
    end

    assign out_data_next = {edit_next, field_sel_next, time_next.seconds,
                            time_next.minutes, time_next.hours};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_div_reg   <= SCAN_DIVISOR_RST;
            hold_delay_reg <= HOLD_DELAY_RST;
            repeat_int_reg <= REPEAT_INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SCAN_DIVISOR:    scan_div_reg   <= cfg_data[7:0];
                CFG_HOLD_DELAY:      hold_delay_reg <= cfg_data;
                CFG_REPEAT_INTERVAL: repeat_int_reg <= cfg_data[7:0];
                default:             ; // drop writes beyond the register list
            endcase
        end
    end

    // Clock state: advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            field_sel_reg <= FIELD_HOURS;
            edit_reg      <= 1'b1;
            latch_reg     <= 3'd0;
            armed_reg     <= 1'b0;
            hold_cnt_reg  <= 16'd0;
            rpt_cnt_reg   <= 8'd0;
            scan_cnt_reg  <= 8'd0;
        end else if (accept) begin
            time_reg      <= time_next;
            field_sel_reg <= field_sel_next;
            edit_reg      <= edit_next;
            latch_reg     <= latch_next;
            armed_reg     <= armed_next;
            hold_cnt_reg  <= hold_cnt_next;
            rpt_cnt_reg   <= rpt_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
        end
    end

    // Output register: fill on accept, empty when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

    // Time fields stay in range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        time_reg.hours < HOURS_PER_DAY && time_reg.minutes < MINUTES_PER_HOUR &&
        time_reg.seconds < SECONDS_PER_MIN)
        else $error("time field out of range");

    // Leaving edit mode always selects hours
    a_run_selects_hours: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(edit_reg) |-> field_sel_reg == FIELD_HOURS)
        else $error("run entered without hours selected");

    // A second tick in edit mode leaves the time alone
    a_edit_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == ACT_SECOND && edit_reg |=> $stable(time_reg))
        else $error("time moved while editing");

    // Every accepted beat leaves a result waiting whose hours and edit flag match the new state
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg && out_data_reg[4:0] == time_reg.hours &&
                   out_data_reg[19] == edit_reg)
        else $error("result does not follow accepted beat");

    // Key2 release disarms repeat
    a_release_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(latch_reg[1]) |-> !armed_reg && hold_cnt_reg == 16'd0)
        else $error("repeat still armed after key2 release");

endmodule
